FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define DPU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPU_ASSERT_CLK(lbl, prop, msg) \
  `DPU_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define DPU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPU_ASSERT_CLK(lbl, prop, msg)
`endif

`endif

FILE: sv/dpu_pkg.sv
// ----------------------------------------------------------------------------
// dpu_pkg
// shared types, constants and saturation helpers for the depth pixel projector
// ----------------------------------------------------------------------------
package dpu_pkg;

  localparam int FRAME_WIDTH          = 320;
  localparam int FRAME_HEIGHT         = 240;
  localparam int UNDISTORT_ITERATIONS = 5;
  localparam int NORM_BITS            = 28;
  localparam int DIV_BITS             = 33;

  typedef logic signed [28:0] coord_t;

  typedef enum logic [2:0] {
    REG_PRINCIPAL = 3'd0,
    REG_FOCAL_X   = 3'd1,
    REG_FOCAL_Y   = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    coord_t      x0;
    coord_t      y0;
    coord_t      x;
    coord_t      y;
    logic [15:0] depth;
    logic        bad;
  } item_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v < -72'sd2147483648) begin
      return 32'sh8000_0000;
    end else if (v > 72'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat31(input logic signed [71:0] v);
    if (v < -72'sd2147483647) begin
      return 32'sh8000_0001;
    end else if (v > 72'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic coord_t clamp_coord(input logic signed [71:0] v);
    if (v < -72'sd134217728) begin
      return -29'sd134217728;
    end else if (v > 72'sd134217728) begin
      return 29'sd134217728;
    end
    return v[28:0];
  endfunction

endpackage

FILE: sv/depth_pixel_undistort_project.sv
// ----------------------------------------------------------------------------
// depth_pixel_undistort_project
// depth pixel to undistorted 3-d point, fully pipelined
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock while stall_o is low and returns one 3-d
// point per clock while stall_i is low. The pipeline has 31 stages of
// normalization, 43 stages for each of the five undistortion iterations
// and two output stages, mostly restoring dividers with one quotient bit
// per stage (28 bits for normalization, 33 bits for the reciprocal in each
// iteration). A two-entry output buffer keeps the pipeline running while one
// result waits; stall_o rises only when both entries are full. The user must
// write the registers over APB only while idle; the block does not enforce it.
`include "assert_macros.svh"

module depth_pixel_undistort_project (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [8:0]         pixel_col_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [15:0]        depth_value_i,
  input  logic               depth_invalid_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [15:0]        point_z_o,
  output logic               point_valid_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        z;
    logic               valid;
  } res_t;

  logic [63:0]        pp_q;
  logic [31:0]        fx_q, fy_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;
  dpu_pkg::reg_idx_e  reg_idx;
  logic               wr_en;
  dpu_pkg::coef_t     coef;

  logic               en;
  logic               it_v    [dpu_pkg::UNDISTORT_ITERATIONS+1];
  dpu_pkg::item_t     it_item [dpu_pkg::UNDISTORT_ITERATIONS+1];

  logic               p_v_q;
  logic signed [45:0] p_px_q, p_py_q;
  logic [15:0]        p_depth_q;
  logic               p_bad_q;
  res_t               res_d;

  logic               out_v_q, skid_v_q;
  res_t               out_q, skid_q;

  // configuration
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = dpu_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q <= '0;
      fx_q <= 32'd65536;
      fy_q <= 32'd65536;
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        dpu_pkg::REG_PRINCIPAL: pp_q <= pwdata;
        dpu_pkg::REG_FOCAL_X:   fx_q <= pwdata[31:0];
        dpu_pkg::REG_FOCAL_Y:   fy_q <= pwdata[31:0];
        dpu_pkg::REG_K1:        k1_q <= pwdata[31:0];
        dpu_pkg::REG_K2:        k2_q <= pwdata[31:0];
        dpu_pkg::REG_K3:        k3_q <= pwdata[31:0];
        dpu_pkg::REG_P1:        p1_q <= pwdata[31:0];
        dpu_pkg::REG_P2:        p2_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dpu_pkg::REG_PRINCIPAL: prdata = pp_q;
      dpu_pkg::REG_FOCAL_X:   prdata = {32'd0, fx_q};
      dpu_pkg::REG_FOCAL_Y:   prdata = {32'd0, fy_q};
      dpu_pkg::REG_K1:        prdata = {32'd0, k1_q};
      dpu_pkg::REG_K2:        prdata = {32'd0, k2_q};
      dpu_pkg::REG_K3:        prdata = {32'd0, k3_q};
      dpu_pkg::REG_P1:        prdata = {32'd0, p1_q};
      dpu_pkg::REG_P2:        prdata = {32'd0, p2_q};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    coef.k1 = k1_q;
    coef.k2 = k2_q;
    coef.k3 = k3_q;
    coef.p1 = p1_q;
    coef.p2 = p2_q;
  end

  // datapath
  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  dpu_norm u_norm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (valid_i),
    .pixel_col_i     (pixel_col_i),
    .pixel_row_i     (pixel_row_i),
    .depth_value_i   (depth_value_i),
    .depth_invalid_i (depth_invalid_i),
    .cx_i            (pp_q[31:0]),
    .cy_i            (pp_q[63:32]),
    .fx_i            (fx_q),
    .fy_i            (fy_q),
    .valid_o         (it_v[0]),
    .item_o          (it_item[0])
  );

  for (genvar i = 0; i < dpu_pkg::UNDISTORT_ITERATIONS; i++) begin : g_iter
    dpu_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (it_v[i]),
      .item_i  (it_item[i]),
      .coef_i  (coef),
      .valid_o (it_v[i+1]),
      .item_o  (it_item[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= it_v[dpu_pkg::UNDISTORT_ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_px_q    <= it_item[dpu_pkg::UNDISTORT_ITERATIONS].x
                   * $signed({1'b0, it_item[dpu_pkg::UNDISTORT_ITERATIONS].depth});
      p_py_q    <= it_item[dpu_pkg::UNDISTORT_ITERATIONS].y
                   * $signed({1'b0, it_item[dpu_pkg::UNDISTORT_ITERATIONS].depth});
      p_depth_q <= it_item[dpu_pkg::UNDISTORT_ITERATIONS].depth;
      p_bad_q   <= it_item[dpu_pkg::UNDISTORT_ITERATIONS].bad;
    end
  end

  always_comb begin
    res_d = '0;
    if (!p_bad_q) begin
      res_d.x     = dpu_pkg::sat32(72'(p_px_q >>> 12));
      res_d.y     = dpu_pkg::sat32(72'(p_py_q >>> 12));
      res_d.z     = p_depth_q;
      res_d.valid = 1'b1;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (p_v_q) begin
      if (out_v_q && stall_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (!stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!stall_i) begin
        out_q <= skid_q;
      end
    end else if (p_v_q) begin
      if (out_v_q && stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign valid_o       = out_v_q;
  assign point_x_o     = out_q.x;
  assign point_y_o     = out_q.y;
  assign point_z_o     = out_q.z;
  assign point_valid_o = out_q.valid;

  `DPU_ASSERT_CLK(a_skid_needs_out, skid_v_q |-> out_v_q, "skid entry full with output empty")
  `DPU_ASSERT_CLK(a_invalid_zero, valid_o && !point_valid_o |-> point_x_o == 0 && point_y_o == 0 && point_z_o == 0, "invalid point not zero")

endmodule

FILE: sv/dpu_norm.sv
// ----------------------------------------------------------------------------
// dpu_norm
// pixel normalization by principal point and focal length, pipelined divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpu_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [8:0]     pixel_col_i,
  input  logic [7:0]     pixel_row_i,
  input  logic [15:0]    depth_value_i,
  input  logic           depth_invalid_i,
  input  logic [31:0]    cx_i,
  input  logic [31:0]    cy_i,
  input  logic [31:0]    fx_i,
  input  logic [31:0]    fy_i,
  output logic           valid_o,
  output dpu_pkg::item_t item_o
);

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [3:0]  mlo;
    logic [32:0] r;
    logic [27:0] q;
    logic [31:0] f;
  } ndiv_t;

  function automatic ndiv_t nstart(input logic [33:0] diff, input logic [31:0] f);
    logic [33:0] mag;
    ndiv_t       n;
    mag   = diff[33] ? (34'd0 - diff) : diff;
    n.neg = diff[33];
    n.ovf = {4'b0, mag[31:0]} >= {f, 4'b0};
    n.mlo = mag[3:0];
    n.r   = 33'(mag[31:4]);
    n.q   = '0;
    n.f   = f;
    return n;
  endfunction

  function automatic ndiv_t nstep(input ndiv_t s);
    logic [32:0] rs;
    ndiv_t       n;
    rs    = {s.r[31:0], s.mlo[3]};
    n     = s;
    n.mlo = {s.mlo[2:0], 1'b0};
    if (rs >= {1'b0, s.f}) begin
      n.r = rs - {1'b0, s.f};
      n.q = {s.q[26:0], 1'b1};
    end else begin
      n.r = rs;
      n.q = {s.q[26:0], 1'b0};
    end
    return n;
  endfunction

  function automatic dpu_pkg::coord_t nfinish(input ndiv_t s);
    logic [27:0] qm;
    qm = s.q;
    if (s.ovf || (s.q > 28'h800_0000)) begin
      qm = 28'h800_0000;
    end
    return s.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  endfunction

  logic        s0_v_q;
  logic [33:0] s0_dx_q, s0_dy_q;
  logic [31:0] s0_fx_q, s0_fy_q;
  logic [15:0] s0_depth_q;
  logic        s0_bad_q;

  logic        nv_q   [dpu_pkg::NORM_BITS+1];
  ndiv_t       nx_q   [dpu_pkg::NORM_BITS+1];
  ndiv_t       ny_q   [dpu_pkg::NORM_BITS+1];
  logic [15:0] ndep_q [dpu_pkg::NORM_BITS+1];
  logic        nbad_q [dpu_pkg::NORM_BITS+1];

  logic           out_v_q;
  dpu_pkg::item_t out_item_q;
  dpu_pkg::item_t out_item_d;
  logic           bad_d;

  assign bad_d = depth_invalid_i
               || ({23'd0, pixel_col_i} >= 32'(dpu_pkg::FRAME_WIDTH))
               || ({24'd0, pixel_row_i} >= 32'(dpu_pkg::FRAME_HEIGHT));

  always_comb begin
    out_item_d       = '0;
    out_item_d.x0    = nfinish(nx_q[dpu_pkg::NORM_BITS]);
    out_item_d.y0    = nfinish(ny_q[dpu_pkg::NORM_BITS]);
    out_item_d.x     = out_item_d.x0;
    out_item_d.y     = out_item_d.y0;
    out_item_d.depth = ndep_q[dpu_pkg::NORM_BITS];
    out_item_d.bad   = nbad_q[dpu_pkg::NORM_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      nv_q[0] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q  <= valid_i;
      nv_q[0] <= s0_v_q;
      out_v_q <= nv_q[dpu_pkg::NORM_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_dx_q    <= 34'({pixel_col_i, 16'h0}) - 34'(cx_i);
      s0_dy_q    <= 34'({pixel_row_i, 16'h0}) - 34'(cy_i);
      s0_fx_q    <= (fx_i < 32'd65536) ? 32'd65536 : fx_i;
      s0_fy_q    <= (fy_i < 32'd65536) ? 32'd65536 : fy_i;
      s0_depth_q <= depth_value_i;
      s0_bad_q   <= bad_d;
      nx_q[0]    <= nstart(s0_dx_q, s0_fx_q);
      ny_q[0]    <= nstart(s0_dy_q, s0_fy_q);
      ndep_q[0]  <= s0_depth_q;
      nbad_q[0]  <= s0_bad_q;
      out_item_q <= out_item_d;
    end
  end

  for (genvar s = 0; s < dpu_pkg::NORM_BITS; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[s+1] <= 1'b0;
      end else if (en_i) begin
        nv_q[s+1] <= nv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[s+1]   <= nstep(nx_q[s]);
        ny_q[s+1]   <= nstep(ny_q[s]);
        ndep_q[s+1] <= ndep_q[s];
        nbad_q[s+1] <= nbad_q[s];
      end
    end
  end

  assign valid_o = out_v_q;
  assign item_o  = out_item_q;

  `DPU_ASSERT_CLK(a_norm_rem_x, nv_q[dpu_pkg::NORM_BITS] && !nx_q[dpu_pkg::NORM_BITS].ovf |-> nx_q[dpu_pkg::NORM_BITS].r < 33'(nx_q[dpu_pkg::NORM_BITS].f), "x remainder not below divisor")
  `DPU_ASSERT_CLK(a_norm_rem_y, nv_q[dpu_pkg::NORM_BITS] && !ny_q[dpu_pkg::NORM_BITS].ovf |-> ny_q[dpu_pkg::NORM_BITS].r < 33'(ny_q[dpu_pkg::NORM_BITS].f), "y remainder not below divisor")

endmodule

FILE: sv/dpu_iter.sv
// ----------------------------------------------------------------------------
// dpu_iter
// one pipelined iteration of the inverse radial and tangential distortion
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpu_iter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  dpu_pkg::item_t item_i,
  input  dpu_pkg::coef_t coef_i,
  output logic           valid_o,
  output dpu_pkg::item_t item_o
);

  typedef struct packed {
    logic [38:0] d;
    logic [39:0] r;
    logic [32:0] q;
  } idiv_t;

  function automatic idiv_t div_step(input idiv_t s);
    logic [39:0] rs;
    idiv_t       n;
    rs = {s.r[38:0], 1'b0};
    n  = s;
    if (rs >= {1'b0, s.d}) begin
      n.r = rs - {1'b0, s.d};
      n.q = {s.q[31:0], 1'b1};
    end else begin
      n.r = rs;
      n.q = {s.q[31:0], 1'b0};
    end
    return n;
  endfunction

  // squares and cross product
  logic                a_v_q;
  dpu_pkg::item_t      a_item_q;
  logic signed [57:0]  a_xx_q, a_yy_q, a_xy_q;
  // radius and tangential terms
  logic                b_v_q;
  dpu_pkg::item_t      b_item_q;
  logic signed [31:0]  b_r2_q, b_t_q, b_u_q, b_w_q;
  logic signed [31:0]  b_r2_d, b_t_d, b_u_d, b_w_d;
  logic signed [71:0]  xx_w, yy_w, xy_w;
  // products
  logic                c_v_q;
  dpu_pkg::item_t      c_item_q;
  logic signed [31:0]  c_r2_q;
  logic signed [63:0]  c_m1_q, c_p1t_q, c_p2u_q, c_p1w_q, c_p2t_q;
  logic                d_v_q;
  dpu_pkg::item_t      d_item_q;
  logic signed [31:0]  d_r2_q, d_a1_q, d_dx_q, d_dy_q;
  logic                e_v_q;
  dpu_pkg::item_t      e_item_q;
  logic signed [31:0]  e_r2_q, e_dx_q, e_dy_q;
  logic signed [63:0]  e_m2_q;
  logic                f_v_q;
  dpu_pkg::item_t      f_item_q;
  logic signed [31:0]  f_r2_q, f_a2_q, f_dx_q, f_dy_q;
  logic                g_v_q;
  dpu_pkg::item_t      g_item_q;
  logic signed [63:0]  g_m3_q;
  logic signed [31:0]  g_ex_q, g_ey_q;
  logic signed [71:0]  den_w;
  idiv_t               div_init;
  // divider chain
  logic                dv_v_q    [dpu_pkg::DIV_BITS+1];
  dpu_pkg::item_t      dv_item_q [dpu_pkg::DIV_BITS+1];
  logic signed [31:0]  dv_ex_q   [dpu_pkg::DIV_BITS+1];
  logic signed [31:0]  dv_ey_q   [dpu_pkg::DIV_BITS+1];
  idiv_t               dv_st_q   [dpu_pkg::DIV_BITS+1];
  // rescale
  logic                i_v_q;
  dpu_pkg::item_t      i_item_q;
  logic signed [65:0]  i_px_q, i_py_q;
  logic                j_v_q;
  dpu_pkg::item_t      j_item_q;
  dpu_pkg::item_t      j_item_d;

  always_comb begin
    xx_w   = 72'(a_xx_q >>> 24);
    yy_w   = 72'(a_yy_q >>> 24);
    xy_w   = 72'(a_xy_q >>> 24);
    b_r2_d = dpu_pkg::sat32(xx_w + yy_w);
    b_t_d  = dpu_pkg::sat32(xy_w + xy_w);
    b_u_d  = dpu_pkg::sat32(72'(b_r2_d) + xx_w + xx_w);
    b_w_d  = dpu_pkg::sat32(72'(b_r2_d) + yy_w + yy_w);
  end

  always_comb begin
    den_w      = 72'sd16777216 + 72'(g_m3_q >>> 24);
    div_init.d = (den_w < 72'sd65536) ? 39'd65536 : den_w[38:0];
    div_init.r = 40'd32768;
    div_init.q = '0;
  end

  always_comb begin
    j_item_d   = i_item_q;
    j_item_d.x = dpu_pkg::clamp_coord(72'(i_px_q >>> 24));
    j_item_d.y = dpu_pkg::clamp_coord(72'(i_py_q >>> 24));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      d_v_q     <= 1'b0;
      e_v_q     <= 1'b0;
      f_v_q     <= 1'b0;
      g_v_q     <= 1'b0;
      dv_v_q[0] <= 1'b0;
      i_v_q     <= 1'b0;
      j_v_q     <= 1'b0;
    end else if (en_i) begin
      a_v_q     <= valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      d_v_q     <= c_v_q;
      e_v_q     <= d_v_q;
      f_v_q     <= e_v_q;
      g_v_q     <= f_v_q;
      dv_v_q[0] <= g_v_q;
      i_v_q     <= dv_v_q[dpu_pkg::DIV_BITS];
      j_v_q     <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q     <= item_i;
      a_xx_q       <= item_i.x * item_i.x;
      a_yy_q       <= item_i.y * item_i.y;
      a_xy_q       <= item_i.x * item_i.y;

      b_item_q     <= a_item_q;
      b_r2_q       <= b_r2_d;
      b_t_q        <= b_t_d;
      b_u_q        <= b_u_d;
      b_w_q        <= b_w_d;

      c_item_q     <= b_item_q;
      c_r2_q       <= b_r2_q;
      c_m1_q       <= coef_i.k3 * b_r2_q;
      c_p1t_q      <= coef_i.p1 * b_t_q;
      c_p2u_q      <= coef_i.p2 * b_u_q;
      c_p1w_q      <= coef_i.p1 * b_w_q;
      c_p2t_q      <= coef_i.p2 * b_t_q;

      d_item_q     <= c_item_q;
      d_r2_q       <= c_r2_q;
      d_a1_q       <= dpu_pkg::sat32(72'(c_m1_q >>> 24) + 72'(coef_i.k2));
      d_dx_q       <= dpu_pkg::sat32(72'(c_p1t_q >>> 24) + 72'(c_p2u_q >>> 24));
      d_dy_q       <= dpu_pkg::sat32(72'(c_p1w_q >>> 24) + 72'(c_p2t_q >>> 24));

      e_item_q     <= d_item_q;
      e_r2_q       <= d_r2_q;
      e_dx_q       <= d_dx_q;
      e_dy_q       <= d_dy_q;
      e_m2_q       <= d_a1_q * d_r2_q;

      f_item_q     <= e_item_q;
      f_r2_q       <= e_r2_q;
      f_dx_q       <= e_dx_q;
      f_dy_q       <= e_dy_q;
      f_a2_q       <= dpu_pkg::sat32(72'(e_m2_q >>> 24) + 72'(coef_i.k1));

      g_item_q     <= f_item_q;
      g_m3_q       <= f_a2_q * f_r2_q;
      g_ex_q       <= dpu_pkg::sat31(72'(f_item_q.x0) - 72'(f_dx_q));
      g_ey_q       <= dpu_pkg::sat31(72'(f_item_q.y0) - 72'(f_dy_q));

      dv_item_q[0] <= g_item_q;
      dv_ex_q[0]   <= g_ex_q;
      dv_ey_q[0]   <= g_ey_q;
      dv_st_q[0]   <= div_init;

      i_item_q     <= dv_item_q[dpu_pkg::DIV_BITS];
      i_px_q       <= dv_ex_q[dpu_pkg::DIV_BITS]
                      * $signed({1'b0, dv_st_q[dpu_pkg::DIV_BITS].q});
      i_py_q       <= dv_ey_q[dpu_pkg::DIV_BITS]
                      * $signed({1'b0, dv_st_q[dpu_pkg::DIV_BITS].q});

      j_item_q     <= j_item_d;
    end
  end

  for (genvar s = 0; s < dpu_pkg::DIV_BITS; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[s+1] <= dv_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_item_q[s+1] <= dv_item_q[s];
        dv_ex_q[s+1]   <= dv_ex_q[s];
        dv_ey_q[s+1]   <= dv_ey_q[s];
        dv_st_q[s+1]   <= div_step(dv_st_q[s]);
      end
    end
  end

  assign valid_o = j_v_q;
  assign item_o  = j_item_q;

  `DPU_ASSERT_CLK(a_div_rem, dv_v_q[dpu_pkg::DIV_BITS] |-> dv_st_q[dpu_pkg::DIV_BITS].r < 40'(dv_st_q[dpu_pkg::DIV_BITS].d), "divider remainder not below divisor")

endmodule
